// ----- rtl/lprs_pkg.sv -----
`default_nettype none
package lprs_pkg;

	localparam int unsigned CLEAR_PAGES_DEF   = 9;
	localparam int unsigned CLEAR_COLUMNS_DEF = 132;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] MAX_PAINT_COLUMNS = 8'd132;
	localparam logic [3:0] MAX_PAINT_PAGES   = 4'd8;

	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_PAINT = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] KIND_INIT = 2'd0;
	localparam logic [1:0] KIND_ADDR = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	localparam logic [2:0] CFG_PAINT_COLUMNS  = 3'd0;
	localparam logic [2:0] CFG_PAINT_PAGES    = 3'd1;
	localparam logic [2:0] CFG_RESISTOR_RATIO = 3'd2;
	localparam logic [2:0] CFG_VOLUME_LEVEL   = 3'd3;
	localparam logic [2:0] CFG_SCROLL_START   = 3'd4;

	localparam logic [7:0] RST_PAINT_COLUMNS  = 8'd128;
	localparam logic [3:0] RST_PAINT_PAGES    = 4'd8;
	localparam logic [2:0] RST_RESISTOR_RATIO = 3'd5;
	localparam logic [5:0] RST_VOLUME_LEVEL   = 6'd34;
	localparam logic [5:0] RST_SCROLL_START   = 6'd48;

	localparam logic [7:0] CMD_SYS_RESET    = 8'hE2;
	localparam logic [7:0] CMD_SEG_REVERSE  = 8'hA1;
	localparam logic [7:0] CMD_COM_REVERSE  = 8'hC8;
	localparam logic [7:0] CMD_BIAS         = 8'hA2;
	localparam logic [7:0] CMD_POWER_ON     = 8'h2F;
	localparam logic [7:0] CMD_RATIO        = 8'h20;
	localparam logic [7:0] CMD_VOLUME       = 8'h81;
	localparam logic [7:0] CMD_NORMAL       = 8'hA6;
	localparam logic [7:0] CMD_SCROLL       = 8'h40;
	localparam logic [7:0] CMD_ALL_PIX_OFF  = 8'hA4;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'hAF;
	localparam logic [7:0] CMD_PAGE         = 8'hB0;
	localparam logic [7:0] CMD_COL_HIGH     = 8'h10;
	localparam logic [7:0] CMD_COL_LOW      = 8'h00;

	localparam logic [3:0] INIT_LAST_IDX = 4'd11;
	localparam logic [3:0] ADDR_LAST_IDX = 4'd3;

	typedef struct packed {
		logic [7:0] paint_columns;
		logic [3:0] paint_pages;
		logic [2:0] resistor_ratio;
		logic [5:0] volume_level;
		logic [5:0] scroll_start;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] page;
		logic [7:0] data;
	} desc_t;

	function automatic logic [7:0] init_byte(logic [3:0] idx, logic [2:0] ratio,
			logic [5:0] vol, logic [5:0] scroll);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = CMD_SYS_RESET;
			4'd1:    b = CMD_SEG_REVERSE;
			4'd2:    b = CMD_COM_REVERSE;
			4'd3:    b = CMD_BIAS;
			4'd4:    b = CMD_POWER_ON;
			4'd5:    b = CMD_RATIO | {5'd0, ratio};
			4'd6:    b = CMD_VOLUME;
			4'd7:    b = {2'd0, vol};
			4'd8:    b = CMD_NORMAL;
			4'd9:    b = CMD_SCROLL | {2'd0, scroll};
			4'd10:   b = CMD_ALL_PIX_OFF;
			default: b = CMD_DISPLAY_ON;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/lprs_front.sv -----
`default_nettype none
module lprs_front #(
	parameter int unsigned CLEAR_PAGES   = lprs_pkg::CLEAR_PAGES_DEF,
	parameter int unsigned CLEAR_COLUMNS = lprs_pkg::CLEAR_COLUMNS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [7:0]      s_tdata,
	input  wire logic [2:0]      s_tuser,
	input  wire lprs_pkg::cfg_t  cfg,
	input  wire logic            q_full,
	output logic                 q_push,
	output lprs_pkg::desc_t      q_desc
);

	localparam logic [4:0] ClearPages   = 5'(CLEAR_PAGES);
	localparam logic [7:0] ClearColumns = 8'(CLEAR_COLUMNS);

	logic [3:0] page_q;
	logic [7:0] col_q;
	logic [1:0] op;
	logic       start;
	logic       accept;
	logic [4:0] pages;
	logic [7:0] cols;
	logic [7:0] data;
	logic       restart;
	logic [3:0] page0;
	logic [7:0] col0;
	logic [8:0] col_inc;
	logic [4:0] page_inc;
	logic [3:0] page_nxt;
	logic [7:0] col_nxt;

	assign op       = s_tuser[1:0];
	assign start    = s_tuser[2];
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (op == lprs_pkg::OP_CLEAR) begin
			pages = ClearPages;
			cols  = ClearColumns;
			data  = 8'd0;
		end else begin
			if (cfg.paint_pages == 4'd0) begin
				pages = 5'd1;
			end else if (cfg.paint_pages > lprs_pkg::MAX_PAINT_PAGES) begin
				pages = {1'b0, lprs_pkg::MAX_PAINT_PAGES};
			end else begin
				pages = {1'b0, cfg.paint_pages};
			end
			if (cfg.paint_columns == 8'd0) begin
				cols = 8'd1;
			end else if (cfg.paint_columns > lprs_pkg::MAX_PAINT_COLUMNS) begin
				cols = lprs_pkg::MAX_PAINT_COLUMNS;
			end else begin
				cols = cfg.paint_columns;
			end
			data = s_tdata;
		end
	end

	assign restart  = start || ({1'b0, page_q} >= pages) || (col_q >= cols);
	assign page0    = restart ? 4'd0 : page_q;
	assign col0     = restart ? 8'd0 : col_q;
	assign col_inc  = {1'b0, col0} + 9'd1;
	assign page_inc = {1'b0, page0} + 5'd1;

	always_comb begin
		if (col_inc >= {1'b0, cols}) begin
			col_nxt  = 8'd0;
			page_nxt = (page_inc >= pages) ? 4'd0 : page_inc[3:0];
		end else begin
			col_nxt  = col_inc[7:0];
			page_nxt = page0;
		end
	end

	assign q_push      = accept && (op != lprs_pkg::OP_NONE);
	assign q_desc.kind = (op == lprs_pkg::OP_INIT) ? lprs_pkg::KIND_INIT :
		((col0 == 8'd0) ? lprs_pkg::KIND_ADDR : lprs_pkg::KIND_DATA);
	assign q_desc.page = page0;
	assign q_desc.data = data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= 4'd0;
			col_q  <= 8'd0;
		end else if (accept) begin
			unique case (op)
				lprs_pkg::OP_INIT: begin
					page_q <= 4'd0;
					col_q  <= 8'd0;
				end
				lprs_pkg::OP_CLEAR, lprs_pkg::OP_PAINT: begin
					page_q <= page_nxt;
					col_q  <= col_nxt;
				end
				default: begin
					page_q <= page_q;
					col_q  <= col_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lprs_queue.sv -----
`default_nettype none
module lprs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire lprs_pkg::desc_t push_desc,
	output logic                 full,
	input  wire logic            pop,
	output logic                 head_valid,
	output lprs_pkg::desc_t      head_desc
);

	localparam int unsigned Depth  = lprs_pkg::QUEUE_DEPTH;
	localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CountW = $clog2(Depth + 1);

	lprs_pkg::desc_t    mem_q [Depth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CountW-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == CountW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_desc  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CountW'(1);
				2'b01:   count_q <= count_q - CountW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(Depth))
		else $error("queue count exceeds depth");
	a_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("item pushed into a full queue");
	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - CountW'(1))
		else $error("pop did not reduce the queue count");
`endif

endmodule
`default_nettype wire

// ----- rtl/lprs_back.sv -----
`default_nettype none
module lprs_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lprs_pkg::cfg_t  cfg,
	input  wire logic            head_valid,
	input  wire lprs_pkg::desc_t head_desc,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [7:0]           m_tdata,
	output logic                 m_tuser,
	output logic                 m_tlast
);

	logic [3:0] idx_q;
	logic [3:0] eff_idx;
	logic [7:0] byte_nxt;
	logic       is_data_nxt;
	logic       last_nxt;
	logic       emit;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_is_data_q;
	logic       out_last_q;

	assign eff_idx = (head_desc.kind == lprs_pkg::KIND_DATA) ? lprs_pkg::ADDR_LAST_IDX : idx_q;

	always_comb begin
		unique case (head_desc.kind)
			lprs_pkg::KIND_INIT: begin
				byte_nxt    = lprs_pkg::init_byte(eff_idx, cfg.resistor_ratio,
					cfg.volume_level, cfg.scroll_start);
				is_data_nxt = 1'b0;
				last_nxt    = (eff_idx == lprs_pkg::INIT_LAST_IDX);
			end
			default: begin
				unique case (eff_idx[1:0])
					2'd0:    byte_nxt = lprs_pkg::CMD_PAGE | {4'd0, head_desc.page};
					2'd1:    byte_nxt = lprs_pkg::CMD_COL_HIGH;
					2'd2:    byte_nxt = lprs_pkg::CMD_COL_LOW;
					default: byte_nxt = head_desc.data;
				endcase
				is_data_nxt = (eff_idx == lprs_pkg::ADDR_LAST_IDX);
				last_nxt    = (eff_idx == lprs_pkg::ADDR_LAST_IDX);
			end
		endcase
	end

	assign emit = head_valid && (!out_valid_q || m_tready);
	assign pop  = emit && last_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q <= last_nxt ? 4'd0 : eff_idx + 4'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q    <= byte_nxt;
			out_is_data_q <= is_data_nxt;
			out_last_q    <= last_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_is_data_q;
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= lprs_pkg::INIT_LAST_IDX)
		else $error("byte index out of range");
	a_addr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && head_desc.kind != lprs_pkg::KIND_INIT |-> idx_q <= lprs_pkg::ADDR_LAST_IDX)
		else $error("address sequence index out of range");
	a_pop_resets_idx: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 4'd0 && m_tvalid && m_tlast)
		else $error("item retired without a final byte");
`endif

endmodule
`default_nettype wire

// ----- rtl/lcd_page_refresh_sequencer.sv -----
`default_nettype none
// Byte sequencer for a page-organized monochrome LCD on an SPI link.
// The slave stream takes one item per handshake: s_tuser holds the operation
// (init, clear byte, paint byte) and the start-of-frame flag, s_tdata the pixel
// byte. The master stream gives one byte per handshake, with m_tuser high for
// display data and m_tlast on the final byte that an item causes.
// The configuration channel writes the paint window, contrast ratio, volume
// and scroll line; it is always ready. The user must see that it is written
// only while the block is idle; the block does not enforce it. The front
// keeps the page and column position and turns each item into a descriptor
// in a two-entry queue. The back expands descriptors into bytes through a
// single output register, one byte per cycle while the receiver is ready. An
// item is taken in the cycle it is offered while the queue has room; its first
// byte passes a queue entry and the output register. A data byte in a page
// gives one byte, one at column zero adds page and column commands first, and
// init twelve bytes. A stall holds the output register, fills the queue and
// drops s_tready. Reset clears position, queue, output valid, loads cfg defaults.
module lcd_page_refresh_sequencer #(
	parameter int unsigned CLEAR_PAGES   = lprs_pkg::CLEAR_PAGES_DEF,
	parameter int unsigned CLEAR_COLUMNS = lprs_pkg::CLEAR_COLUMNS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // pixel_byte
	input  wire logic [2:0] s_tuser,   // operation[1:0], start_frame[2]
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // byte_value
	output logic            m_tuser,   // is_data
	output logic            m_tlast,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	lprs_pkg::cfg_t  cfg_q;
	lprs_pkg::desc_t push_desc;
	lprs_pkg::desc_t head_desc;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            head_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.paint_columns  <= lprs_pkg::RST_PAINT_COLUMNS;
			cfg_q.paint_pages    <= lprs_pkg::RST_PAINT_PAGES;
			cfg_q.resistor_ratio <= lprs_pkg::RST_RESISTOR_RATIO;
			cfg_q.volume_level   <= lprs_pkg::RST_VOLUME_LEVEL;
			cfg_q.scroll_start   <= lprs_pkg::RST_SCROLL_START;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lprs_pkg::CFG_PAINT_COLUMNS:  cfg_q.paint_columns  <= cfg_data;
				lprs_pkg::CFG_PAINT_PAGES:    cfg_q.paint_pages    <= cfg_data[3:0];
				lprs_pkg::CFG_RESISTOR_RATIO: cfg_q.resistor_ratio <= cfg_data[2:0];
				lprs_pkg::CFG_VOLUME_LEVEL:   cfg_q.volume_level   <= cfg_data[5:0];
				lprs_pkg::CFG_SCROLL_START:   cfg_q.scroll_start   <= cfg_data[5:0];
				default:                      cfg_q                <= cfg_q;
			endcase
		end
	end

	lprs_front #(
		.CLEAR_PAGES   (CLEAR_PAGES),
		.CLEAR_COLUMNS (CLEAR_COLUMNS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_desc   (push_desc)
	);

	lprs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (push_desc),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	lprs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire
